FILE: rtl/wavetable_morph_sampler_top_macros.svh
// Assertion helpers for the morph sampler
`ifndef WAVETABLE_MORPH_SAMPLER_TOP_MACROS_SVH
`define WAVETABLE_MORPH_SAMPLER_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset
`define WMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wms check failed");

// Next-cycle implication checked outside reset
`define WMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wms check failed");

`endif

FILE: rtl/wms_pkg.sv
package wms_pkg;

  localparam logic [1:0] OP_WR_ENTRY = 2'd0;
  localparam logic [1:0] OP_WR_LEVEL = 2'd1;
  localparam logic [1:0] OP_SAMPLE   = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  localparam logic [1:0] CFG_MORPH   = 2'd0;
  localparam logic [1:0] CFG_NTABLES = 2'd1;
  localparam logic [1:0] CFG_LENGTH  = 2'd2;

  localparam int CFG_W = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DIV,
    ST_RD_A,
    ST_RD_B,
    ST_INTERP,
    ST_NEXT,
    ST_BLEND,
    ST_OUT
  } wms_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;   // capture input item and prepare
    logic mem_write;   // write table word
    logic lvl_write;   // write slot level
    logic scan_rd;     // read level at scan pointer
    logic scan_step;   // evaluate level read, advance pointer
    logic div_start;
    logic div_step;
    logic rd_a;        // read word i of current table
    logic rd_b;        // read word j, latch word i
    logic interp;      // interpolate with word j, latch result
    logic sel_upper;   // switch to upper table
    logic blend;       // final blend
    logic out_load;    // load output register
  } wms_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic two_tables;
    logic div_done;
  } wms_sts_t;

endpackage

FILE: rtl/wms_if.sv
interface wms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  table_slot;
  logic [9:0]  entry_index;
  logic signed [15:0] entry_value;
  logic [15:0] level_value;
  logic [16:0] phase;

  modport source (output valid, op, table_slot, entry_index, entry_value, level_value,
                  phase, input ready);
  modport sink (input valid, op, table_slot, entry_index, entry_value, level_value,
                phase, output ready);
endinterface

interface wms_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

FILE: rtl/wms_ram.sv
module wms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/wms_ctrl.sv
module wms_ctrl
  import wms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [1:0] in_op,
  input  logic       out_busy,
  input  wms_sts_t   sts,
  output logic       in_ready,
  output wms_cmd_t   cmd
);
  wms_state_t state_r, state_nxt;
  logic       second_r, second_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_op == OP_SAMPLE) begin
          state_nxt  = ST_SCAN;
          second_nxt = 1'b0;
        end
      end
      ST_SCAN:      state_nxt = ST_SCAN_WAIT;
      ST_SCAN_WAIT: state_nxt = sts.scan_done ? ST_DIV : ST_SCAN;
      ST_DIV:       if (sts.div_done) state_nxt = ST_RD_A;
      ST_RD_A:      state_nxt = ST_RD_B;
      ST_RD_B:      state_nxt = ST_INTERP;
      ST_INTERP:    state_nxt = (sts.two_tables && !second_r) ? ST_NEXT : ST_BLEND;
      ST_NEXT: begin
        state_nxt  = ST_RD_A;
        second_nxt = 1'b1;
      end
      ST_BLEND:     state_nxt = ST_OUT;
      ST_OUT:       if (!out_busy) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_item = 1'b1;
          cmd.mem_write = (in_op == OP_WR_ENTRY);
          cmd.lvl_write = (in_op == OP_WR_LEVEL);
        end
      end
      ST_SCAN:      cmd.scan_rd = 1'b1;
      ST_SCAN_WAIT: begin
        cmd.scan_step = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_DIV:       cmd.div_step = 1'b1;
      ST_RD_A:      cmd.rd_a = 1'b1;
      ST_RD_B:      cmd.rd_b = 1'b1;
      ST_INTERP:    cmd.interp = 1'b1;
      ST_NEXT:      cmd.sel_upper = 1'b1;
      ST_BLEND:     cmd.blend = 1'b1;
      ST_OUT:       cmd.out_load = !out_busy;
      default:      cmd = '0;
    endcase
  end
endmodule

FILE: rtl/wms_dpath.sv
module wms_dpath
  import wms_pkg::*;
#(
  parameter int MAX_TABLES  = 8,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_table_slot,
  input  logic [9:0]         in_entry_index,
  input  logic signed [15:0] in_entry_value,
  input  logic [15:0]        in_level_value,
  input  logic [16:0]        in_phase,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  wms_cmd_t           cmd,
  output wms_sts_t           sts,
  output logic signed [15:0] result
);
  localparam int SW = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int AW = $clog2(MAX_TABLES * TABLE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = $clog2(MAX_TABLES + 1);

  // Configuration registers
  logic [15:0] morph_r;
  logic [3:0]  ntab_r;
  logic [10:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      morph_r <= '0;
      ntab_r  <= 4'd1;
      len_r   <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MORPH:   morph_r <= cfg_data[15:0];
        CFG_NTABLES: ntab_r  <= cfg_data[3:0];
        CFG_LENGTH:  len_r   <= cfg_data[10:0];
        default:     ;
      endcase
    end
  end

  // Effective count and length
  logic [CW-1:0] n_eff;
  logic [LW-1:0] len_eff;
  always_comb begin
    if (ntab_r == 4'd0) n_eff = CW'(1);
    else if (32'(ntab_r) > MAX_TABLES) n_eff = CW'(MAX_TABLES);
    else n_eff = CW'(ntab_r);
    if (len_r < 11'd2) len_eff = LW'(2);
    else if (32'(len_r) > TABLE_DEPTH) len_eff = LW'(TABLE_DEPTH);
    else len_eff = LW'(len_r);
  end

  // Load address checks
  logic slot_ok, idx_ok;
  assign slot_ok = 32'(in_table_slot) < MAX_TABLES;
  assign idx_ok  = 32'(in_entry_index) < TABLE_DEPTH;

  // Level and table memories
  logic [SW-1:0] lvl_raddr;
  logic [15:0]   lvl_rdata;
  wms_ram #(.WIDTH(16), .DEPTH(1 << SW)) u_lvl (
    .clk(clk), .we(cmd.lvl_write && slot_ok), .waddr(SW'(in_table_slot)),
    .wdata(in_level_value), .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  logic [AW-1:0] tab_raddr;
  logic [15:0]   tab_rdata;
  logic [AW-1:0] tab_waddr;
  assign tab_waddr = AW'(32'(in_table_slot) * TABLE_DEPTH + 32'(in_entry_index));
  wms_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_tab (
    .clk(clk), .we(cmd.mem_write && slot_ok && idx_ok), .waddr(tab_waddr),
    .wdata(in_entry_value), .raddr(tab_raddr), .rdata(tab_rdata)
  );

  // Phase position, index and fraction
  logic [15:0]    pwr_r;
  logic [IW-1:0]  idx_i_r, idx_j_r;
  logic [15:0]    frac_r;
  logic [16+LW-1:0] pos;
  logic [LW-1:0]  ii, jj;
  assign pos = (16+LW)'(pwr_r) * (16+LW)'(len_eff);
  always_comb begin
    ii = pos[16+LW-1:16];
    if (ii >= len_eff) ii = len_eff - LW'(1);
    jj = ii + LW'(1);
    if (jj >= len_eff) jj = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) pwr_r <= in_phase[15:0];
    if (cmd.scan_rd) begin
      idx_i_r <= IW'(ii);
      idx_j_r <= IW'(jj);
      frac_r  <= pos[15:0];
    end
  end

  // Bracket scan over slot levels
  logic [CW-1:0] k_r, up_r;
  logic          found_r;
  logic [15:0]   lo_lvl_r, prev_lvl_r, hi_lvl_r;
  logic          hit, last;
  assign lvl_raddr = SW'(k_r);
  assign hit  = lvl_rdata >= morph_r;
  assign last = (k_r + CW'(1)) >= n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0; found_r <= 1'b0; up_r <= '0;
    end else if (cmd.load_item) begin
      k_r <= '0; found_r <= 1'b0; up_r <= '0;
    end else if (cmd.scan_step) begin
      prev_lvl_r <= lvl_rdata;
      if (hit) begin
        found_r <= 1'b1;
        up_r <= k_r;
        hi_lvl_r <= lvl_rdata;
        lo_lvl_r <= prev_lvl_r;
      end else if (last) begin
        found_r <= 1'b1;
        up_r <= n_eff;
      end else begin
        k_r <= k_r + CW'(1);
      end
    end
  end

  logic two_tables;
  assign two_tables = (n_eff != CW'(1)) && (up_r != '0) && (up_r != n_eff);
  assign sts.scan_done  = hit || last;
  assign sts.two_tables = two_tables;

  // Restoring divider: alpha = (morph - lo) * 2^16 / gap, 32 steps, 17-bit quotient
  logic [16:0] quo_r;
  logic [16:0] rem_r;
  logic [31:0] dvd_r;
  logic [5:0]  dcnt_r;
  logic [16:0] gap;
  logic [17:0] trial;
  assign gap   = {1'b0, hi_lvl_r} - {1'b0, lo_lvl_r};
  assign trial = {rem_r, dvd_r[31]} - {1'b0, gap};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= 6'd33;
    end else if (cmd.div_step && dcnt_r != 6'd0) begin
      dcnt_r <= dcnt_r - 6'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      if (dcnt_r == 6'd33) begin
        dvd_r <= {(morph_r - lo_lvl_r), 16'd0};
        rem_r <= '0;
        quo_r <= '0;
      end else if (dcnt_r != 6'd0) begin
        if (!trial[17]) rem_r <= trial[16:0];
        else rem_r <= {rem_r[15:0], dvd_r[31]};
        quo_r <= {quo_r[15:0], !trial[17]};
        dvd_r <= {dvd_r[30:0], 1'b0};
      end
    end
  end
  assign sts.div_done = (dcnt_r == 6'd1) || (dcnt_r == 6'd0);

  // Table select and reads
  logic [CW-1:0] tsel_r;
  logic [CW-1:0] first_sel;
  always_comb begin
    if (!two_tables) first_sel = (up_r == n_eff) ? (n_eff - CW'(1)) : '0;
    else first_sel = up_r - CW'(1);
  end
  always_ff @(posedge clk) begin
    if (cmd.div_step) tsel_r <= first_sel;
    else if (cmd.sel_upper) tsel_r <= up_r;
  end
  always_comb begin
    tab_raddr = AW'(32'(tsel_r) * TABLE_DEPTH + 32'(idx_i_r));
    if (cmd.rd_b) tab_raddr = AW'(32'(tsel_r) * TABLE_DEPTH + 32'(idx_j_r));
  end

  // Interpolation and blend: a + floor((w*(b-a) + 2^15) / 2^16)
  logic signed [15:0] wa_r;
  logic signed [17:0] sa_r, sb_r;
  logic signed [17:0] bl_a, bl_b;
  logic        [16:0] bl_w;
  logic signed [36:0] bl_prod;
  logic signed [18:0] bl_res;
  always_comb begin
    if (cmd.blend) begin
      bl_a = sa_r; bl_b = sb_r; bl_w = quo_r;
    end else begin
      bl_a = 18'(wa_r); bl_b = 18'($signed(tab_rdata)); bl_w = {1'b0, frac_r};
    end
    bl_prod = $signed({1'b0, bl_w}) * 37'(bl_b - bl_a) + 37'sd32768;
    bl_res  = 19'(bl_a) + 19'(bl_prod >>> 16);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_b) wa_r <= $signed(tab_rdata);
    if (cmd.interp) begin
      if (tsel_r == up_r && two_tables) sb_r <= bl_res[17:0];
      else sa_r <= bl_res[17:0];
    end
  end

  // Final result with saturation
  logic signed [18:0] fin;
  logic signed [18:0] fin_r;
  assign fin = two_tables ? bl_res : 19'(sa_r);
  always_ff @(posedge clk) begin
    if (cmd.blend) fin_r <= fin;
  end
  always_comb begin
    if (fin_r > 19'sd32767) result = 16'sd32767;
    else if (fin_r < -19'sd32768) result = -16'sd32768;
    else result = fin_r[15:0];
  end
endmodule

FILE: rtl/wavetable_morph_sampler_top.sv
// Sequence: a sample transaction runs from acceptance to result valid through the serial
// level scan (a read state and an evaluate state per slot scanned), the alpha divider
// and one or two interpolations (read A, read B, interpolate), then blend and output.
// One sample transaction at a time: the next is accepted in the cycle after the
// result is loaded (later while the previous result waits); loads finish on acceptance.
// Reset: synchronous active-low rst_n clears control and configuration; tables undefined.
`include "wavetable_morph_sampler_top_macros.svh"
module wavetable_morph_sampler_top
  import wms_pkg::*;
#(
  parameter int MAX_TABLES  = 8,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  wms_in_if.sink           in_ch,
  wms_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  wms_cmd_t cmd;
  wms_sts_t sts;
  logic     in_fire;
  logic     out_valid_r;
  logic signed [15:0] out_sample_r;
  logic signed [15:0] result;

  assign in_fire = in_ch.valid && in_ch.ready;

  wms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(in_ch.op),
    .out_busy(out_valid_r && !out_ch.ready), .sts(sts),
    .in_ready(in_ch.ready), .cmd(cmd)
  );

  wms_dpath #(.MAX_TABLES(MAX_TABLES), .TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk(clk), .rst_n(rst_n), .in_table_slot(in_ch.table_slot),
    .in_entry_index(in_ch.entry_index), .in_entry_value(in_ch.entry_value),
    .in_level_value(in_ch.level_value), .in_phase(in_ch.phase),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .result(result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_sample_r <= result;
  end
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

  `WMS_ASSERT_IMP(a_no_load_when_busy, cmd.out_load, !(out_valid_r && !out_ch.ready))
  `WMS_ASSERT_NXT(a_load_sets_valid, cmd.out_load, out_valid_r)
  `WMS_ASSERT_IMP(a_one_mem_cmd, 1'b1, $onehot0({cmd.mem_write, cmd.lvl_write, cmd.blend}))
endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
module tb;
  import wms_pkg::*;

  localparam int NSLOT = 8;
  localparam int DEPTH = 1024;
  localparam int FILL = 32;
  localparam int DRAIN = 80;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  wms_in_if in_ch();
  wms_out_if out_ch();

  wavetable_morph_sampler_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the block's tables and registers
  logic signed [15:0] wave_mem [NSLOT][DEPTH];
  logic [15:0] slot_lvl [NSLOT];
  logic [15:0] morph_reg;
  logic [3:0] ntab_reg;
  logic [10:0] len_reg;

  logic signed [15:0] pending_samples [$];
  int errors;
  longint cycles;
  bit no_idle;
  int out_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // a + floor((w * (b - a) + 1/2)), w in unsigned Q1.16
  function automatic int mix(int a, int b, int unsigned w);
    longint prod;
    prod = longint'(w) * longint'(b - a) + 64'sd32768;
    return a + int'(prod >>> 16);
  endfunction

  function automatic int interp_lookup(int slot, int unsigned p, int unsigned len);
    int unsigned pos, i, f, j;
    pos = p * len;
    i = pos >> 16;
    f = pos & 32'hFFFF;
    if (i >= len) i = len - 1;
    j = i + 1;
    if (j >= len) j = 0;
    return mix(wave_mem[slot][i], wave_mem[slot][j], f);
  endfunction

  function automatic logic signed [15:0] morph_sample(logic [16:0] phase);
    int unsigned len, n, p, up, lo, hi, alpha;
    int r;
    len = len_reg;
    if (len < 2) len = 2;
    if (len > DEPTH) len = DEPTH;
    n = ntab_reg;
    if (n < 1) n = 1;
    if (n > NSLOT) n = NSLOT;
    p = phase;
    if (p >= 65536) p -= 65536;
    up = n;
    for (int k = int'(n) - 1; k >= 0; k--)
      if (slot_lvl[k] >= morph_reg) up = k;
    if (n == 1 || up == 0) begin
      r = interp_lookup(0, p, len);
    end else if (up == n) begin
      r = interp_lookup(n - 1, p, len);
    end else begin
      lo = slot_lvl[up - 1];
      hi = slot_lvl[up];
      alpha = ((morph_reg - lo) << 16) / (hi - lo);
      r = mix(interp_lookup(up - 1, p, len), interp_lookup(up, p, len), alpha);
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Update the shadow for one accepted transaction
  task automatic apply_item(logic [1:0] op, logic [2:0] slot, logic [9:0] idx,
                            logic [15:0] val, logic [15:0] lvl, logic [16:0] phase);
    case (op)
      OP_WR_ENTRY: wave_mem[slot][idx] = val;
      OP_WR_LEVEL: slot_lvl[slot] = lvl;
      OP_SAMPLE: pending_samples.push_back(morph_sample(phase));
      default: ;
    endcase
  endtask

  // Drive one transaction and wait for its acceptance
  task automatic send_item(logic [1:0] op, logic [2:0] slot, logic [9:0] idx,
                           logic [15:0] val, logic [15:0] lvl, logic [16:0] phase);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op <= op;
    in_ch.table_slot <= slot;
    in_ch.entry_index <= idx;
    in_ch.entry_value <= val;
    in_ch.level_value <= lvl;
    in_ch.phase <= phase;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(op, slot, idx, val, lvl, phase);
  endtask

  task automatic send_sample(logic [16:0] phase);
    send_item(OP_SAMPLE, 3'($urandom), 10'($urandom), 16'($urandom), 16'($urandom), phase);
  endtask

  // Hold input idle until every sample is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MORPH: morph_reg = data;
      CFG_NTABLES: ntab_reg = data[3:0];
      CFG_LENGTH: len_reg = data[10:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] morph, logic [3:0] n, logic [10:0] len);
    drain();
    write_reg(CFG_MORPH, morph);
    write_reg(CFG_NTABLES, {12'd0, n});
    write_reg(CFG_LENGTH, {5'd0, len});
  endtask

  // Load ascending levels and the low entries of every slot
  task automatic test_table_load();
    for (int s = 0; s < NSLOT; s++) begin
      send_item(OP_WR_LEVEL, 3'(s), 10'($urandom), 16'($urandom), 16'(s * 9000 + 1000),
                17'($urandom));
      for (int e = 0; e < FILL; e++)
        send_item(OP_WR_ENTRY, 3'(s), 10'(e),
                  (e == 0) ? 16'h8000 : (e == 1) ? 16'h7FFF : 16'($urandom),
                  16'($urandom), 17'($urandom));
    end
  endtask

  // Phase extremes, morph at levels and beyond, unused op
  task automatic test_directed();
    set_config(16'd0, 4'd8, 11'd32);
    send_sample(17'd0);
    send_sample(17'd65535);
    send_sample(17'd65536);
    send_sample(17'h1FFFF);
    set_config(16'd10000, 4'd8, 11'd2);
    send_sample(17'd32768);
    send_sample(17'd49152);
    send_item(OP_UNUSED, 3'd7, 10'h3FF, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
    send_sample(17'd12345);
    set_config(16'd19000, 4'd15, 11'd0);
    send_sample(17'd40000);
    set_config(16'd65535, 4'd0, 11'd1);
    send_sample(17'd70000);
    set_config(16'd65535, 4'd8, 11'd31);
    send_sample(17'd20000);
    set_config(16'd5000, 4'd1, 11'd17);
    send_sample(17'd99999);
  endtask

  // Random traffic in phases, each with its own register setting
  task automatic test_random();
    int pick;
    for (int ph = 0; ph < 10; ph++) begin
      set_config((ph % 3 == 0) ? 16'hFFFF : (ph % 3 == 1) ? 16'h0 : 16'($urandom),
                 4'($urandom_range(0, 15)),
                 (ph % 4 == 0) ? 11'($urandom_range(0, 1)) : 11'($urandom_range(2, FILL)));
      no_idle = (ph == 4);
      for (int it = 0; it < 40; it++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          send_sample(17'($urandom));
        else if (pick < 85)
          send_item(OP_WR_ENTRY, 3'($urandom),
                    ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, FILL - 1)),
                    16'($urandom), 16'($urandom), 17'($urandom));
        else if (pick < 95)
          send_item(OP_WR_LEVEL, 3'($urandom), 10'($urandom), 16'($urandom), 16'($urandom),
                    17'($urandom));
        else
          send_item(OP_UNUSED, 3'($urandom), 10'($urandom), 16'($urandom), 16'($urandom),
                    17'($urandom));
        // Pause the sender once until the block has caught up
        if (ph == 6 && it == 20) begin
          @(negedge clk);
          in_ch.valid <= 1'b0;
          while (pending_samples.size() != 0) @(negedge clk);
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // Sample slot 0 at full length; phases stay on the written low entries or wrap at the end
  task automatic test_full_length();
    send_item(OP_WR_ENTRY, 3'd0, 10'd1023, 16'($urandom), 16'($urandom), 17'($urandom));
    set_config(16'($urandom), 4'd1, 11'd1024);
    repeat (15) send_sample(17'($urandom_range(0, (FILL - 1) * 64 - 1)));
    send_sample(17'd65535);
    send_sample(17'h1FFFF);
    set_config(16'd0, 4'd0, 11'h7FF);
    repeat (15) send_sample(17'($urandom_range(65536, 65536 + (FILL - 1) * 64 - 1)));
  endtask

  initial begin
    errors = 0;
    no_idle = 1'b0;
    morph_reg = 16'd0;
    ntab_reg = 4'd1;
    len_reg = 11'd1024;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MORPH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_WR_ENTRY;
    in_ch.table_slot = '0;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.level_value = '0;
    in_ch.phase = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_table_load();
    test_directed();
    test_random();
    test_full_length();
    drain();
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // Random backpressure on the result side: ready waits a drawn delay per result, held high while no_idle
  initial begin
    out_ch.ready = 1'b0;
    out_stall = 0;
  end
  always @(negedge clk) begin
    if (no_idle) begin
      out_ch.ready <= 1'b1;
      out_stall <= 0;
    end else if (out_ch.ready) begin
      out_ch.ready <= 1'b0;
      out_stall <= $urandom_range(0, 14);
    end else if (out_ch.valid) begin
      if (out_stall > 0)
        out_stall <= out_stall - 1;
      else
        out_ch.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expected sample
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample: expected none, actual %0d", $realtime,
                 out_ch.sample);
        errors++;
      end else begin
        if (out_ch.sample !== pending_samples[0]) begin
          $display("%0t: sample mismatch: expected %0d, actual %0d", $realtime,
                   pending_samples[0], out_ch.sample);
          errors++;
        end
        void'(pending_samples.pop_front());
      end
    end
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/wms_pkg.sv
rtl/wms_if.sv
rtl/wms_ram.sv
rtl/wms_ctrl.sv
rtl/wms_dpath.sv
rtl/wavetable_morph_sampler_top.sv
tb/tb.sv
